@@ design/sat_pkg.sv @@
// segment address translator: shared types, constants and codes
// no dependencies; used by every other file of the block
`default_nettype none

package sat_pkg;

  // size of the segment table, one cell per entry
  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned ADDR_W = 32;
  // counter width: holds 0 .. MAX_SEGMENTS
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned INDEX_W = 4;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_ADDR2OFF = 2'd1,
    ACT_OFF2ADDR = 2'd2,
    ACT_UNKNOWN  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNBACKED = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESENT = 2'd0,
    CFG_BASE    = 2'd1,
    CFG_SIZE    = 2'd2,
    CFG_COUNT   = 2'd3
  } cfg_idx_e;

  // item as it travels down the chain of cells
  typedef struct packed {
    logic              valid;
    action_e           act;
    logic              wr;        // entry write still pending
    logic [CNT_W-1:0]  rem;       // cells left to walk, or cells until the written entry
    logic              done;      // outcome settled
    status_e           status;
    logic [ADDR_W-1:0] q;         // query value
    logic [ADDR_W-1:0] packed_off;// running packed offset
    logic [ADDR_W-1:0] rel;       // query minus packed offset (offset to address)
    logic [ADDR_W-1:0] res;       // hit distance or translated address
    logic [ADDR_W-1:0] wr_start;
    logic [ADDR_W-1:0] wr_length;
    logic              wr_unbacked;
  } tok_t;

endpackage

`default_nettype wire

@@ design/sat_cell.sv @@
// one segment cell: holds a table entry and advances the item by one cell a cycle
// depends on sat_pkg
`default_nettype none

module sat_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  sat_pkg::tok_t     tok_i,
  output sat_pkg::tok_t     tok_o
);
  import sat_pkg::*;

  logic [ADDR_W-1:0] start_q;
  logic [ADDR_W-1:0] length_q;
  logic              unbacked_q;
  tok_t              tok_d;
  tok_t              tok_q;
  logic              wr_here;
  logic              active;
  logic [ADDR_W-1:0] delta;
  logic              hit_addr;
  logic              hit_off;

  assign wr_here  = tok_i.valid && tok_i.wr && (tok_i.rem == '0);
  assign active   = tok_i.valid && !tok_i.done && (tok_i.rem != '0);
  assign delta    = tok_i.q - start_q;
  assign hit_addr = (tok_i.q >= start_q) && (delta < length_q);
  assign hit_off  = (tok_i.q >= tok_i.packed_off) && (tok_i.rel < length_q);

  // entry storage, written by an entry-write item when it reaches its cell
  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      start_q    <= tok_i.wr_start;
      length_q   <= tok_i.wr_length;
      unbacked_q <= tok_i.wr_unbacked;
    end
  end

  // walk step for this segment
  always_comb begin
    tok_d = tok_i;
    if (tok_i.rem != '0) begin
      tok_d.rem = tok_i.rem - CNT_W'(1);
    end
    if (wr_here) begin
      tok_d.wr = 1'b0;
    end
    if (active) begin
      case (tok_i.act)
        ACT_ADDR2OFF: begin
          if (hit_addr) begin
            tok_d.done   = 1'b1;
            tok_d.status = unbacked_q ? ST_UNBACKED : ST_OK;
            tok_d.res    = delta;
          end else if (!unbacked_q) begin
            tok_d.packed_off = tok_i.packed_off + length_q;
          end
        end
        ACT_OFF2ADDR: begin
          if (!unbacked_q) begin
            if (hit_off) begin
              tok_d.done   = 1'b1;
              tok_d.status = ST_OK;
              tok_d.res    = start_q + tok_i.rel;
            end else begin
              tok_d.packed_off = tok_i.packed_off + length_q;
              tok_d.rel        = tok_i.rel - length_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hand the item to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

@@ design/segment_address_translator.sv @@
// segment address translator top level: configuration, item entry, cell chain, result
// depends on sat_pkg and sat_cell
//
//   channel   | handshake          | signals
//   ----------+--------------------+-----------------------------------------------
//   item in   | start && !busy     | action_i entry_index_i entry_start_i
//             |                    | entry_length_i entry_unbacked_i query_value_i
//   result    | done_o (one cycle) | status_o result_value_o
//   config    | cfg_we_i           | cfg_idx_i cfg_wdata_i
//
// an item walks the row of MAX_SEGMENTS cells, one cell a cycle, and its result
// is registered after the last cell and shows on done_o. one item is in flight
// at a time: busy is high from acceptance until the result cycle, and a new item
// may start in the result cycle.
// reset clears configuration and control; the segment table holds nothing
// meaningful until written. results cannot be held off by the receiver.
`default_nettype none

module segment_address_translator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [1:0]                    action_i,
  input  wire logic [sat_pkg::INDEX_W-1:0]   entry_index_i,
  input  wire logic [sat_pkg::ADDR_W-1:0]    entry_start_i,
  input  wire logic [sat_pkg::ADDR_W-1:0]    entry_length_i,
  input  wire logic                          entry_unbacked_i,
  input  wire logic [sat_pkg::ADDR_W-1:0]    query_value_i,
  output      logic                          done_o,
  output      logic [1:0]                    status_o,
  output      logic [sat_pkg::ADDR_W-1:0]    result_value_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sat_pkg::ADDR_W-1:0]    cfg_wdata_i
);
  import sat_pkg::*;

  logic                  present_q;
  logic [ADDR_W-1:0]     base_q;
  logic [ADDR_W-1:0]     size_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  busy_q;
  logic                  busy_d;
  logic                  accept;
  logic [CNT_W-1:0]      used;
  logic                  idx_ok;
  action_e               act;
  tok_t                  chain [MAX_SEGMENTS+1];
  tok_t                  last;
  logic [ADDR_W-1:0]     off_sum;
  status_e               fin_status;
  logic [ADDR_W-1:0]     fin_value;
  logic                  done_q;
  status_e               status_q;
  logic [ADDR_W-1:0]     value_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      base_q    <= '0;
      size_q    <= '0;
      count_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PRESENT: present_q <= cfg_wdata_i[0];
        CFG_BASE:    base_q    <= cfg_wdata_i;
        CFG_SIZE:    size_q    <= cfg_wdata_i;
        CFG_COUNT:   count_q   <= cfg_wdata_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = start && !busy_q;
  assign act    = action_e'(action_i);

  // segments in use, clamped to the table size
  always_comb begin
    if (32'(count_q) > 32'(MAX_SEGMENTS)) begin
      used = CNT_W'(MAX_SEGMENTS);
    end else begin
      used = CNT_W'(count_q);
    end
  end

  assign idx_ok = 32'(entry_index_i) < 32'(MAX_SEGMENTS);

  // item entry: settle early outcomes and flat mode, prime the walk
  always_comb begin
    chain[0]             = '0;
    chain[0].valid       = accept;
    chain[0].act         = act;
    chain[0].q           = query_value_i;
    chain[0].rel         = query_value_i;
    chain[0].wr_start    = entry_start_i;
    chain[0].wr_length   = entry_length_i;
    chain[0].wr_unbacked = entry_unbacked_i;
    chain[0].status      = ST_OK;
    case (act)
      ACT_WRITE: begin
        chain[0].done = 1'b1;
        chain[0].wr   = idx_ok;
        chain[0].rem  = idx_ok ? CNT_W'(entry_index_i) : '0;
      end
      ACT_ADDR2OFF: begin
        if (!present_q) begin
          chain[0].done   = 1'b1;
          chain[0].status = ST_INVALID;
        end else if (used == '0) begin
          chain[0].done = 1'b1;
          if (query_value_i < base_q) begin
            chain[0].status = ST_INVALID;
          end else begin
            chain[0].res = query_value_i - base_q;
          end
        end else begin
          chain[0].rem = used;
        end
      end
      ACT_OFF2ADDR: begin
        if (!present_q || (query_value_i >= size_q)) begin
          chain[0].done   = 1'b1;
          chain[0].status = ST_INVALID;
        end else if (used == '0) begin
          chain[0].done = 1'b1;
          chain[0].res  = base_q + query_value_i;
        end else begin
          chain[0].rem = used;
        end
      end
      default: begin
        chain[0].done   = 1'b1;
        chain[0].status = ST_INVALID;
      end
    endcase
  end

  // row of segment cells
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    sat_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign last    = chain[MAX_SEGMENTS];
  assign off_sum = last.packed_off + last.res;

  // final check: packed offset against image size, zero on failure
  always_comb begin
    fin_status = last.done ? last.status : ST_INVALID;
    if ((last.act == ACT_ADDR2OFF) && (fin_status == ST_OK) && (off_sum >= size_q)) begin
      fin_status = ST_INVALID;
    end
    if (fin_status != ST_OK) begin
      fin_value = '0;
    end else if (last.act == ACT_ADDR2OFF) begin
      fin_value = off_sum;
    end else begin
      fin_value = last.res;
    end
  end

  // one item in flight
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last.valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= last.valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (last.valid) begin
      status_q <= fin_status;
      value_q  <= fin_value;
    end
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_value_o = value_q;

endmodule

`default_nettype wire

@@ design/sat_checker.sv @@
// port-level checks for the segment address translator, bound to the top level
// depends on sat_pkg and segment_address_translator
`default_nettype none

module sat_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic [1:0]                    status_o,
  input wire logic [sat_pkg::ADDR_W-1:0]    result_value_o
);
  import sat_pkg::*;

  // an accepted item holds the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accepted");

  // the result comes after the full walk of the cell row
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(MAX_SEGMENTS+1) done_o)
    else $error("result missing at expected cycle");

  // the block is free again in the result cycle
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy still high with result");

  // one result per item
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result repeated");

  // failed translations carry a zero value
  a_zero_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (result_value_o == '0))
    else $error("non-zero value with failed status");

endmodule

bind segment_address_translator sat_checker u_sat_checker (.*);

`default_nettype wire

@@ sim/sat_translation_checker.sv @@
// checker for the segment address translator: watches the item, result and register
// channels, predicts every result from its own copy of table and registers, compares
// depends on sat_pkg
`default_nettype none

module sat_translation_checker
  import sat_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [1:0]           action_i,
  input  wire logic [INDEX_W-1:0]   entry_index_i,
  input  wire logic [ADDR_W-1:0]    entry_start_i,
  input  wire logic [ADDR_W-1:0]    entry_length_i,
  input  wire logic                 entry_unbacked_i,
  input  wire logic [ADDR_W-1:0]    query_value_i,
  input  wire logic                 done_o,
  input  wire logic [1:0]           status_o,
  input  wire logic [ADDR_W-1:0]    result_value_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] value;
  } xlat_t;

  // own copy of the registers and the segment table
  logic                cfg_present;
  logic [ADDR_W-1:0]   cfg_base;
  logic [ADDR_W-1:0]   cfg_size;
  logic [COUNT_W-1:0]  cfg_count;
  logic [ADDR_W-1:0]   tbl_start    [MAX_SEGMENTS];
  logic [ADDR_W-1:0]   tbl_len      [MAX_SEGMENTS];
  logic                tbl_unbacked [MAX_SEGMENTS];

  xlat_t expected_xlat_q[$];
  xlat_t oldest;
  xlat_t next_xlat;
  int    fails = 0;

  assign fail_count_o = fails;

  // a count above the table size walks the whole table
  function automatic int unsigned entries_in_use();
    return (cfg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(cfg_count);
  endfunction

  // address to packed offset: flat or segment walk, first hit wins
  function automatic xlat_t predict_addr_to_offset(input logic [ADDR_W-1:0] addr);
    xlat_t             r;
    int unsigned       n;
    int unsigned       i;
    logic [ADDR_W-1:0] run_off;
    logic [ADDR_W-1:0] delta;
    logic [ADDR_W-1:0] off;
    r.status = ST_INVALID;
    r.value  = '0;
    n        = entries_in_use();
    if (!cfg_present) return r;
    if (n == 0) begin
      off = addr - cfg_base;
      if (addr >= cfg_base && off < cfg_size) begin
        r.status = ST_OK;
        r.value  = off;
      end
      return r;
    end
    run_off = '0;
    for (i = 0; i < n; i++) begin
      delta = addr - tbl_start[i];
      if (addr >= tbl_start[i] && delta < tbl_len[i]) begin
        off = run_off + delta;
        if (tbl_unbacked[i]) begin
          r.status = ST_UNBACKED;
        end else if (off < cfg_size) begin
          r.status = ST_OK;
          r.value  = off;
        end
        return r;
      end
      // unbacked segments take no image space
      if (!tbl_unbacked[i]) run_off = run_off + tbl_len[i];
    end
    return r;
  endfunction

  // packed offset to address: only backed segments cover the image
  function automatic xlat_t predict_offset_to_addr(input logic [ADDR_W-1:0] off);
    xlat_t             r;
    int unsigned       n;
    int unsigned       i;
    logic [ADDR_W-1:0] from_off;
    logic [ADDR_W-1:0] rel;
    r.status = ST_INVALID;
    r.value  = '0;
    n        = entries_in_use();
    if (!cfg_present || off >= cfg_size) return r;
    if (n == 0) begin
      r.status = ST_OK;
      r.value  = cfg_base + off;
      return r;
    end
    from_off = '0;
    for (i = 0; i < n; i++) begin
      if (!tbl_unbacked[i]) begin
        rel = off - from_off;
        if (off >= from_off && rel < tbl_len[i]) begin
          r.status = ST_OK;
          r.value  = tbl_start[i] + rel;
          return r;
        end
        from_off = from_off + tbl_len[i];
      end
    end
    return r;
  endfunction

  // register writes, result checks, then the prediction for a newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_present = 1'b0;
      cfg_base    = '0;
      cfg_size    = '0;
      cfg_count   = '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        tbl_start[i]    = '0;
        tbl_len[i]      = '0;
        tbl_unbacked[i] = 1'b0;
      end
      expected_xlat_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PRESENT: cfg_present = cfg_wdata_i[0];
          CFG_BASE:    cfg_base    = cfg_wdata_i;
          CFG_SIZE:    cfg_size    = cfg_wdata_i;
          CFG_COUNT:   cfg_count   = cfg_wdata_i[COUNT_W-1:0];
          default:     ;
        endcase
      end

      if (done_o) begin
        if (expected_xlat_q.size() == 0) begin
          $error("result with no item outstanding: status %0d, result_value 0x%08h",
                 status_o, result_value_o);
          fails++;
        end else begin
          oldest = expected_xlat_q.pop_front();
          if (status_o !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, status_o);
            fails++;
          end
          if (result_value_o !== oldest.value) begin
            $error("result_value mismatch: expected 0x%08h, actual 0x%08h",
                   oldest.value, result_value_o);
            fails++;
          end
        end
      end

      if (start && !busy) begin
        next_xlat.status = ST_OK;
        next_xlat.value  = '0;
        case (action_e'(action_i))
          ACT_WRITE: begin
            if (entry_index_i < MAX_SEGMENTS) begin
              tbl_start[entry_index_i]    = entry_start_i;
              tbl_len[entry_index_i]      = entry_length_i;
              tbl_unbacked[entry_index_i] = entry_unbacked_i;
            end
          end
          ACT_ADDR2OFF: next_xlat = predict_addr_to_offset(query_value_i);
          ACT_OFF2ADDR: next_xlat = predict_offset_to_addr(query_value_i);
          default: begin
            next_xlat.status = ST_INVALID;
          end
        endcase
        expected_xlat_q.push_back(next_xlat);
      end

      pending_o <= expected_xlat_q.size();
    end
  end

endmodule

`default_nettype wire

@@ sim/segment_address_translator_test.sv @@
// testbench top for the segment address translator: clock, reset, items, register
// writes and the verdict; prediction and comparison sit in sat_translation_checker
// depends on sat_pkg, sat_translation_checker and the block itself
`default_nettype none

module segment_address_translator_test;
  import sat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 5;
  localparam int N_PHASES        = 40;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int QUIET_PHASES    = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 2 * (MAX_SEGMENTS + 1);

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 item_start = 1'b0;
  logic [1:0]           item_action = ACT_WRITE;
  logic [INDEX_W-1:0]   item_index = '0;
  logic [ADDR_W-1:0]    item_seg_start = '0;
  logic [ADDR_W-1:0]    item_seg_len = '0;
  logic                 item_unbacked = 1'b0;
  logic [ADDR_W-1:0]    item_query = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_PRESENT;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  wire logic            busy;
  wire logic            done;
  wire logic [1:0]      status;
  wire logic [ADDR_W-1:0] result_value;
  int                   fail_count;
  int                   pending;
  int                   stall_cycles = 0;

  // what the stimulus knows of table and registers, used to aim queries
  logic [ADDR_W-1:0]  sh_start [MAX_SEGMENTS];
  logic [ADDR_W-1:0]  sh_len   [MAX_SEGMENTS];
  logic               sh_unb   [MAX_SEGMENTS];
  logic               cur_present = 1'b0;
  logic [ADDR_W-1:0]  cur_base = '0;
  logic [ADDR_W-1:0]  cur_size = '0;
  logic [COUNT_W-1:0] cur_count = '0;
  bit                 idle_on = 1'b1;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  segment_address_translator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .start            (item_start),
    .busy             (busy),
    .action_i         (item_action),
    .entry_index_i    (item_index),
    .entry_start_i    (item_seg_start),
    .entry_length_i   (item_seg_len),
    .entry_unbacked_i (item_unbacked),
    .query_value_i    (item_query),
    .done_o           (done),
    .status_o         (status),
    .result_value_o   (result_value),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  sat_translation_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .start            (item_start),
    .busy             (busy),
    .action_i         (item_action),
    .entry_index_i    (item_index),
    .entry_start_i    (item_seg_start),
    .entry_length_i   (item_seg_len),
    .entry_unbacked_i (item_unbacked),
    .query_value_i    (item_query),
    .done_o           (done),
    .status_o         (status),
    .result_value_o   (result_value),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // watchdog: cycles in which neither an item nor a result is accepted
  always @(posedge clk_i) begin
    if ((item_start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // present one item, hold it until accepted, then maybe idle for a burst
  task automatic send_item(input action_e act, input logic [INDEX_W-1:0] idx,
                           input logic [ADDR_W-1:0] seg_start,
                           input logic [ADDR_W-1:0] seg_len, input logic unb,
                           input logic [ADDR_W-1:0] q);
    int unsigned pick;
    item_action    <= act;
    item_index     <= idx;
    item_seg_start <= seg_start;
    item_seg_len   <= seg_len;
    item_unbacked  <= unb;
    item_query     <= q;
    item_start     <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (idle_on) begin
      pick = $urandom_range(0, 2);
      if (pick != 0) begin
        item_start <= 1'b0;
        // sometimes let the walk finish first so the gap lands after the result
        if (pick == 2) begin
          @(posedge clk_i);
          while (busy) @(posedge clk_i);
        end
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  endtask

  // hold off new items until every outstanding result has come back
  task automatic wait_idle();
    item_start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // all four registers, upper bits of the narrow ones filled with junk
  task automatic set_config(input logic p, input logic [ADDR_W-1:0] b,
                            input logic [ADDR_W-1:0] sz, input logic [COUNT_W-1:0] cnt);
    wait_idle();
    write_reg(CFG_PRESENT, ($urandom & ~32'h1) | 32'(p));
    write_reg(CFG_BASE, b);
    write_reg(CFG_SIZE, sz);
    write_reg(CFG_COUNT, ($urandom & ~32'h1F) | 32'(cnt));
    cfg_we      <= 1'b0;
    cur_present = p;
    cur_base    = b;
    cur_size    = sz;
    cur_count   = cnt;
  endtask

  task automatic put_entry(input logic [INDEX_W-1:0] idx, input logic [ADDR_W-1:0] s,
                           input logic [ADDR_W-1:0] l, input logic u);
    sh_start[idx] = s;
    sh_len[idx]   = l;
    sh_unb[idx]   = u;
    send_item(ACT_WRITE, idx, s, l, u, $urandom);
  endtask

  // rewrite all entries: packed run, overlapping window, extreme values, run over 2^32
  task automatic build_layout(input int unsigned kind);
    logic [ADDR_W-1:0] cursor;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] l;
    int unsigned       i;
    cursor = (kind == 3) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom & 32'h7FFF_F000;
    for (i = 0; i < MAX_SEGMENTS; i++) begin
      case (kind)
        0: begin
          l      = $urandom_range(1, 64);
          s      = cursor;
          cursor = cursor + l + $urandom_range(0, 16);
        end
        1: begin
          s = cursor + $urandom_range(0, 1023);
          l = $urandom_range(0, 256);
        end
        2: begin
          case ($urandom_range(0, 3))
            0:       s = '0;
            1:       s = '1;
            default: s = $urandom;
          endcase
          case ($urandom_range(0, 3))
            0:       l = '0;
            1:       l = '1;
            2:       l = $urandom;
            default: l = $urandom_range(1, 64);
          endcase
        end
        default: begin
          l      = $urandom_range(1, 512);
          s      = cursor;
          cursor = cursor + l + $urandom_range(0, 8);
        end
      endcase
      put_entry(i[INDEX_W-1:0], s, l, $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic int unsigned walk_len(input logic [COUNT_W-1:0] cnt);
    return (cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(cnt);
  endfunction

  // image bytes taken by the backed segments in use
  function automatic logic [ADDR_W-1:0] backed_span(input logic [COUNT_W-1:0] cnt);
    logic [ADDR_W-1:0] sum;
    int unsigned       i;
    sum = '0;
    for (i = 0; i < walk_len(cnt); i++) begin
      if (!sh_unb[i]) sum = sum + sh_len[i];
    end
    return sum;
  endfunction

  // addresses on and around segment or image edges
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       n;
    int unsigned       i;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] l;
    n = walk_len(cur_count);
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0:       return cur_base;
        1:       return cur_base - 1;
        2:       return cur_base + cur_size - 1;
        3:       return cur_base + cur_size;
        default: return cur_base + $urandom_range(0, (cur_size > 4096) ? 4096 : cur_size);
      endcase
    end
    i = $urandom_range(0, n - 1);
    s = sh_start[i];
    l = sh_len[i];
    case ($urandom_range(0, 7))
      0:       return s;
      1:       return s + l - 1;
      2:       return s + l;
      3:       return s - 1;
      default: return s + $urandom_range(0, (l == 0) ? 0 : l - 1);
    endcase
  endfunction

  // offsets on and around packed segment edges and the image end
  function automatic logic [ADDR_W-1:0] pick_offset();
    int unsigned       n;
    int unsigned       i;
    int unsigned       k;
    logic [ADDR_W-1:0] pre;
    logic [ADDR_W-1:0] l;
    n = walk_len(cur_count);
    if (n == 0 || $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return cur_size - 1;
        2:       return cur_size;
        default: return $urandom_range(0, cur_size);
      endcase
    end
    i   = $urandom_range(0, n - 1);
    pre = '0;
    for (k = 0; k < i; k++) begin
      if (!sh_unb[k]) pre = pre + sh_len[k];
    end
    l = sh_len[i];
    case ($urandom_range(0, 5))
      0:       return pre;
      1:       return pre + l - 1;
      2:       return pre + l;
      default: return pre + $urandom_range(0, (l == 0) ? 0 : l - 1);
    endcase
  endfunction

  // one random item: mostly aimed queries, some entry rewrites and noise
  task automatic random_item();
    int unsigned          r;
    logic [INDEX_W-1:0]   idx;
    action_e              act;
    logic [ADDR_W-1:0]    q;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      idx = INDEX_W'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        put_entry(idx, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        put_entry(idx, sh_start[idx] + $urandom_range(0, 32) - 16, $urandom_range(0, 128),
                  $urandom_range(0, 3) == 0);
      end
    end else begin
      if (r < 48) begin
        act = ACT_ADDR2OFF;
        q   = pick_address();
      end else if (r < 86) begin
        act = ACT_OFF2ADDR;
        q   = pick_offset();
      end else if (r < 91) begin
        act = ACT_UNKNOWN;
        q   = $urandom;
      end else begin
        act = (r < 96) ? ACT_ADDR2OFF : ACT_OFF2ADDR;
        q   = $urandom;
      end
      send_item(act, INDEX_W'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)), q);
    end
  endtask

  // register settings for one phase, extremes pinned to fixed phases
  task automatic phase_config(input int p);
    logic               pres;
    logic [ADDR_W-1:0]  b;
    logic [ADDR_W-1:0]  sz;
    logic [ADDR_W-1:0]  span;
    logic [COUNT_W-1:0] cnt;
    int unsigned        r;
    pres = (p % 10 == 3) ? 1'b0 : ($urandom_range(0, 19) != 0);
    r    = $urandom_range(0, 19);
    if (r < 3)      cnt = '0;
    else if (r < 5) cnt = COUNT_W'(MAX_SEGMENTS);
    else if (r < 6) cnt = COUNT_W'($urandom_range(MAX_SEGMENTS + 1, 31));
    else            cnt = COUNT_W'($urandom_range(1, MAX_SEGMENTS));
    if (p == 1) cnt = '0;
    if (p == 2) cnt = COUNT_W'(MAX_SEGMENTS);
    if (p == 5) cnt = 5'd31;
    b    = $urandom;
    span = backed_span(cnt);
    if (cnt == 0) begin
      sz = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
    end else begin
      case ($urandom_range(0, 5))
        0, 1, 2: sz = span;
        3:       sz = (span > 8) ? span - $urandom_range(1, 8) : span;
        4:       sz = span + $urandom_range(1, 64);
        default: sz = $urandom;
      endcase
    end
    if (p == 4) sz = '1;
    if (p == 9) sz = '0;
    if (p == 7) b = '1;
    if (p == 8) b = '0;
    set_config(pres, b, sz, cnt);
  endtask

  // stimulus and verdict
  initial begin
    int p;
    int k;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      sh_start[i] = '0;
      sh_len[i]   = '0;
      sh_unb[i]   = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // no image loaded: everything invalid, unknown action too
    send_item(ACT_ADDR2OFF, '0, '0, '0, 1'b0, '1);
    send_item(ACT_OFF2ADDR, '1, '1, '1, 1'b1, '0);
    send_item(ACT_UNKNOWN, '0, '0, '0, 1'b0, '1);

    // flat mode edges: below base, base, last byte, one past, offset edges
    set_config(1'b1, 32'h0000_8000, 32'h40, '0);
    send_item(ACT_ADDR2OFF, '0, '0, '0, 1'b0, 32'h0000_7FFF);
    send_item(ACT_ADDR2OFF, '0, '0, '0, 1'b0, 32'h0000_8000);
    send_item(ACT_ADDR2OFF, '0, '0, '0, 1'b0, 32'h0000_803F);
    send_item(ACT_ADDR2OFF, '0, '0, '0, 1'b0, 32'h0000_8040);
    send_item(ACT_OFF2ADDR, '0, '0, '0, 1'b0, 32'h3F);
    send_item(ACT_OFF2ADDR, '0, '0, '0, 1'b0, 32'h40);

    // every entry written before any segment walk can read it
    build_layout(0);

    for (p = 0; p < N_PHASES; p++) begin
      if (p >= N_PHASES - QUIET_PHASES) idle_on = 1'b0;
      if (p % 4 == 0) build_layout((p / 4) % 4);
      phase_config(p);
      for (k = 0; k < ITEMS_PER_PHASE; k++) random_item();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ segment_address_translator.f @@
design/sat_pkg.sv
design/sat_cell.sv
design/segment_address_translator.sv
design/sat_checker.sv
sim/sat_translation_checker.sv
sim/segment_address_translator_test.sv
